// ----- rtl/yuvup_pkg.sv -----
// ----------------------------------------------------------------------------
// yuvup_pkg
// shared types and constants of the 4:1:0 to 4:2:0 chroma upsampler
// ----------------------------------------------------------------------------
package yuvup_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int MAX_ROWS  = 512;

  localparam int REG_W   = 10;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int ADDR_W  = $clog2(2 * MAX_WIDTH);
  localparam int DEPTH   = 2 * MAX_WIDTH;

  localparam logic [REG_W-1:0] WIDTH_MIN = REG_W'(2);
  localparam logic [REG_W-1:0] WIDTH_MAX = REG_W'(MAX_WIDTH);
  localparam logic [REG_W-1:0] ROWS_MIN  = REG_W'(1);
  localparam logic [REG_W-1:0] ROWS_MAX  = REG_W'(MAX_ROWS);

  localparam logic [1:0] PH_ABOVE   = 2'd0;
  localparam logic [1:0] PH_CURRENT = 2'd1;
  localparam logic [1:0] PH_BELOW   = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] chroma_sample;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [REG_W-1:0] source_width;
    logic [REG_W-1:0] source_rows;
  } cfg_t;

  typedef struct packed {
    logic [3:0][PIX_W-1:0] h;
    logic [ADDR_W-1:0]     base;
    logic [ROW_W-1:0]      y;
    logic                  line_end;
    logic                  has_above;
    logic                  last_row;
  } job_t;

endpackage

// ----- rtl/yuv410_to_420_chroma_upsampler.sv -----
// ----------------------------------------------------------------------------
// yuv410_to_420_chroma_upsampler
// 2x by 2x chroma upsampler from a 4:1:0 plane to a 4:2:0 plane
// ----------------------------------------------------------------------------
// path: an accepted sample is held as a job, and its words leave through the output stage
// throughput: one word per cycle while pixel_ready is high; a sample gives 2 words
//   (4 at line end) per output row, for one, two or three output rows, set by the single
//   result stage that sequences the line store; the first sample of a line gives no words
// reset: counters, previous sample, sequencer state and output valid clear; line store is not
//   cleared and is read only where the line above was already written
module yuv410_to_420_chroma_upsampler (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  yuvup_pkg::in_word_t   sample,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output yuvup_pkg::out_word_t  pixel,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import yuvup_pkg::*;

  cfg_t cfg;
  job_t job;

  logic [PIX_W-1:0] previous_sample;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [REG_W-1:0] w;
  logic [REG_W-1:0] rows;
  logic [REG_W-1:0] wm1_full;
  logic [REG_W-1:0] rm1_full;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] rm1;
  logic [COL_W-1:0] cc_eff;
  logic [ROW_W-1:0] rc_eff;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;
  logic             line_end;
  logic             last_row;
  logic             take;
  logic             accept;
  logic             load;
  logic [PIX_W:0]   pair_sum;

  yuvup_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.source_width < WIDTH_MIN) begin
      w = WIDTH_MIN;
    end else if (cfg.source_width > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end else begin
      w = cfg.source_width;
    end
    if (cfg.source_rows < ROWS_MIN) begin
      rows = ROWS_MIN;
    end else if (cfg.source_rows > ROWS_MAX) begin
      rows = ROWS_MAX;
    end else begin
      rows = cfg.source_rows;
    end
  end

  assign wm1_full = w - REG_W'(1);
  assign rm1_full = rows - REG_W'(1);
  assign wm1      = wm1_full[COL_W-1:0];
  assign rm1      = rm1_full[ROW_W-1:0];
  assign cc_eff   = sample.frame_start ? '0 : column_count;
  assign rc_eff   = sample.frame_start ? '0 : row_count;
  assign x        = (cc_eff > wm1) ? wm1 : cc_eff;
  assign y        = (rc_eff > rm1) ? rm1 : rc_eff;
  assign line_end = (x == wm1);
  assign last_row = (y == rm1);

  assign sample_ready = take;
  assign accept       = sample_valid && take;
  assign load         = accept && (x != '0);
  assign pair_sum     = {1'b0, previous_sample} + {1'b0, sample.chroma_sample};

  assign job.h[0]      = previous_sample;
  assign job.h[1]      = pair_sum[PIX_W:1];
  assign job.h[2]      = sample.chroma_sample;
  assign job.h[3]      = sample.chroma_sample;
  assign job.base      = ADDR_W'({x - COL_W'(1), 1'b0});
  assign job.y         = y;
  assign job.line_end  = line_end;
  assign job.has_above = (y != '0);
  assign job.last_row  = last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      column_count    <= '0;
      row_count       <= '0;
    end else if (accept) begin
      previous_sample <= sample.chroma_sample;
      if (x == '0) begin
        column_count <= COL_W'(1);
        row_count    <= y;
      end else if (line_end) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : y + ROW_W'(1);
      end else begin
        column_count <= x + COL_W'(1);
        row_count    <= y;
      end
    end
  end

  yuvup_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .job_in    (job),
    .take      (take),
    .out_valid (pixel_valid),
    .out_ready (pixel_ready),
    .out_word  (pixel)
  );

endmodule

// ----- rtl/yuvup_cfg.sv -----
// ----------------------------------------------------------------------------
// yuvup_cfg
// apb register file: source width and source rows
// ----------------------------------------------------------------------------
module yuvup_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output yuvup_pkg::cfg_t      cfg
);
  import yuvup_pkg::*;

  localparam logic REG_SOURCE_WIDTH = 1'b0;
  localparam logic REG_SOURCE_ROWS  = 1'b1;

  logic             wr_en;
  logic [REG_W-1:0] source_width;
  logic [REG_W-1:0] source_rows;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= WIDTH_MIN;
      source_rows  <= ROWS_MIN;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SOURCE_WIDTH: source_width <= pwdata[REG_W-1:0];
        REG_SOURCE_ROWS:  source_rows  <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_WIDTH: prdata = {{(32-REG_W){1'b0}}, source_width};
      REG_SOURCE_ROWS:  prdata = {{(32-REG_W){1'b0}}, source_rows};
      default:          prdata = '0;
    endcase
  end

  assign cfg.source_width = source_width;
  assign cfg.source_rows  = source_rows;

endmodule

// ----- rtl/yuvup_emit.sv -----
// ----------------------------------------------------------------------------
// yuvup_emit
// result sequencer around the line store: reads the line above, writes the
// current line back and emits one word per cycle, while out_ready is high, through an output stage
// ----------------------------------------------------------------------------
module yuvup_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  yuvup_pkg::job_t       job_in,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output yuvup_pkg::out_word_t  out_word
);
  import yuvup_pkg::*;

  logic [PIX_W-1:0] line_store [DEPTH];

  job_t       job;
  logic       job_valid;
  logic [1:0] phase;
  logic [1:0] k;

  logic               b_valid;
  logic [PIX_W-1:0]   b_h;
  logic               b_use_mem;
  logic [COORD_W-1:0] b_row;
  logic [COORD_W-1:0] b_col;
  logic               b_last;
  logic [PIX_W-1:0]   rdata;

  logic               advance_b;
  logic               fire;
  logic [1:0]         kmax;
  logic [1:0]         end_phase;
  logic               job_end;
  logic [ADDR_W-1:0]  addr;
  logic               rd_en;
  logic               wr_en;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] row2;
  logic [PIX_W:0]     mean_sum;

  assign advance_b = !b_valid || out_ready;
  assign fire      = job_valid && advance_b;
  assign kmax      = job.line_end ? 2'd3 : 2'd1;
  assign end_phase = job.last_row ? PH_BELOW : PH_CURRENT;
  assign job_end   = (k == kmax) && (phase == end_phase);
  assign take      = !job_valid || (fire && job_end);
  assign addr      = job.base + ADDR_W'(k);
  assign rd_en     = fire && (phase == PH_ABOVE);
  assign wr_en     = fire && (phase == PH_CURRENT);
  assign row2      = {job.y, 1'b0};

  always_comb begin
    unique case (phase)
      PH_ABOVE:   row = row2 - COORD_W'(1);
      PH_CURRENT: row = row2;
      PH_BELOW:   row = row2 | COORD_W'(1);
      default:    row = row2;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= PH_ABOVE;
      k         <= '0;
    end else if (load) begin
      job_valid <= 1'b1;
      phase     <= job_in.has_above ? PH_ABOVE : PH_CURRENT;
      k         <= '0;
    end else if (fire) begin
      if (job_end) begin
        job_valid <= 1'b0;
      end
      if (k == kmax) begin
        k     <= '0;
        phase <= phase + 2'd1;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (fire) begin
      b_valid <= 1'b1;
    end else if (advance_b) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_h       <= job.h[k];
      b_use_mem <= (phase == PH_ABOVE);
      b_row     <= row;
      b_col     <= COORD_W'(addr);
      b_last    <= job_end;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[addr] <= job.h[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= line_store[addr];
    end
  end

  assign mean_sum = {1'b0, rdata} + {1'b0, b_h};

  assign out_valid            = b_valid;
  assign out_word.pixel_value = b_use_mem ? mean_sum[PIX_W:1] : b_h;
  assign out_word.out_row     = b_row;
  assign out_word.out_col     = b_col;
  assign out_word.last        = b_last;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("line store read and write in one cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> take)
    else $error("job loaded while sequencer busy");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    fire |=> (b_last == $past(job_end)))
    else $error("last flag does not match end of job");

  a_read_needs_above: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> job.has_above)
    else $error("line above read on first source line");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (phase != 2'd3 && phase <= end_phase))
    else $error("phase past end of job");

endmodule
